[hdl/wcu_pkg.sv]
// Shared types and constants of the windowed core utilization block.
// Used by the channel interfaces, the front, the queue and the back.
package wcu_pkg;

	// Field widths of the channels
	localparam int CORE_W  = 3;
	localparam int TICK_W  = 64;
	localparam int USAGE_W = 15;

	// Tick counters in one sample, and adder tree levels to fold them
	localparam int SUM_TERMS  = 8;
	localparam int ADD_LEVELS = 3;
	localparam int LVL_W      = 2;

	// Full scale of the usage value: 100 percent times 256 = 25 * 2^10
	localparam logic [USAGE_W-1:0] FULL_SCALE = 15'd25600;
	localparam int SCALE_SHIFT = 10;
	localparam int ACC_W       = TICK_W + 5;

	// Quotient bits produced by the divider, one per cycle
	localparam int DIV_STEPS = 15;
	localparam int STEP_W    = 4;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	// One classified sample on its way to the back
	typedef struct packed {
		logic [CORE_W-1:0] core;
		logic [TICK_W-1:0] idle;
		logic [TICK_W-1:0] total;
	} queue_item_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_ADD,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_UPDATE,
		B_CHECK,
		B_MUL1,
		B_MUL2,
		B_DIV,
		B_DONE
	} back_state_t;

endpackage

[hdl/wcu_sample_if.sv]
// Input channel of the windowed core utilization block: one counter sample per beat.
// Depends on wcu_pkg for the field widths.
interface wcu_sample_if;
	logic                       valid;
	logic                       ready;
	logic [wcu_pkg::CORE_W-1:0] core_index;
	logic [wcu_pkg::TICK_W-1:0] user_ticks;
	logic [wcu_pkg::TICK_W-1:0] nice_ticks;
	logic [wcu_pkg::TICK_W-1:0] system_ticks;
	logic [wcu_pkg::TICK_W-1:0] idle_ticks;
	logic [wcu_pkg::TICK_W-1:0] iowait_ticks;
	logic [wcu_pkg::TICK_W-1:0] irq_ticks;
	logic [wcu_pkg::TICK_W-1:0] softirq_ticks;
	logic [wcu_pkg::TICK_W-1:0] steal_ticks;

	modport source (
		output valid, core_index, user_ticks, nice_ticks, system_ticks, idle_ticks,
		output iowait_ticks, irq_ticks, softirq_ticks, steal_ticks,
		input  ready
	);
	modport sink (
		input  valid, core_index, user_ticks, nice_ticks, system_ticks, idle_ticks,
		input  iowait_ticks, irq_ticks, softirq_ticks, steal_ticks,
		output ready
	);
endinterface

[hdl/wcu_result_if.sv]
// Output channel of the windowed core utilization block: one usage result per beat.
// Depends on wcu_pkg for the field widths.
interface wcu_result_if;
	logic                        valid;
	logic                        ready;
	logic [wcu_pkg::CORE_W-1:0]  out_core;
	logic                        usage_updated;
	logic [wcu_pkg::USAGE_W-1:0] usage_q8;

	modport source (output valid, out_core, usage_updated, usage_q8, input ready);
	modport sink (input valid, out_core, usage_updated, usage_q8, output ready);
endinterface

[hdl/wcu_front.sv]
// Front of the block: takes a sample beat, folds the eight counters into a total,
// drops samples of unknown cores and pushes the rest into the queue. Uses wcu_pkg.
module wcu_front #(
	parameter int CORE_SLOTS = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	wcu_sample_if.sink           samples,
	output logic                 push,
	output wcu_pkg::queue_item_t push_item,
	input  logic                 queue_full
);

	wcu_pkg::front_state_t state_q, state_d;

	logic [wcu_pkg::TICK_W-1:0] sum_q [wcu_pkg::SUM_TERMS];
	logic [wcu_pkg::TICK_W-1:0] idle_q;
	logic [wcu_pkg::CORE_W-1:0] core_q;
	logic                       keep_q;
	logic [wcu_pkg::LVL_W-1:0]  lvl_q;
	logic                       accept;

	assign accept = samples.valid && samples.ready;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wcu_pkg::F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, ready and push
	always_comb begin
		state_d       = state_q;
		samples.ready = 1'b0;
		push          = 1'b0;
		unique case (state_q)
			wcu_pkg::F_IDLE: begin
				samples.ready = 1'b1;
				if (samples.valid) begin
					state_d = wcu_pkg::F_ADD;
				end
			end
			wcu_pkg::F_ADD: begin
				if (lvl_q == wcu_pkg::LVL_W'(wcu_pkg::ADD_LEVELS - 1)) begin
					state_d = wcu_pkg::F_PUSH;
				end
			end
			wcu_pkg::F_PUSH: begin
				if (!keep_q) begin
					state_d = wcu_pkg::F_IDLE;
				end else if (!queue_full) begin
					push    = 1'b1;
					state_d = wcu_pkg::F_IDLE;
				end
			end
			default: state_d = wcu_pkg::F_IDLE;
		endcase
	end

	// Level counter and range flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q  <= '0;
			keep_q <= 1'b0;
		end else if (accept) begin
			lvl_q  <= '0;
			keep_q <= int'(samples.core_index) < CORE_SLOTS;
		end else if (state_q == wcu_pkg::F_ADD) begin
			lvl_q <= lvl_q + 1'b1;
		end
	end

	// Capture the beat, then fold pairs of partial sums once per level
	always_ff @(posedge clk) begin
		if (accept) begin
			core_q   <= samples.core_index;
			idle_q   <= samples.idle_ticks;
			sum_q[0] <= samples.user_ticks;
			sum_q[1] <= samples.nice_ticks;
			sum_q[2] <= samples.system_ticks;
			sum_q[3] <= samples.idle_ticks;
			sum_q[4] <= samples.iowait_ticks;
			sum_q[5] <= samples.irq_ticks;
			sum_q[6] <= samples.softirq_ticks;
			sum_q[7] <= samples.steal_ticks;
		end else if (state_q == wcu_pkg::F_ADD) begin
			for (int i = 0; i < wcu_pkg::SUM_TERMS / 2; i++) begin
				sum_q[i] <= sum_q[2*i] + sum_q[2*i+1];
			end
		end
	end

	assign push_item = '{core: core_q, idle: idle_q, total: sum_q[0]};

endmodule

[hdl/wcu_queue.sv]
// Short queue between front and back of the utilization block.
// Holds classified samples of type wcu_pkg::queue_item_t.
module wcu_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  wcu_pkg::queue_item_t push_item,
	output logic                 full,
	input  logic                 pop,
	output wcu_pkg::queue_item_t pop_item,
	output logic                 not_empty
);

	wcu_pkg::queue_item_t       slot_q [wcu_pkg::QUEUE_DEPTH];
	logic [wcu_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [wcu_pkg::QCNT_W-1:0] count_q;

	assign full      = count_q == wcu_pkg::QCNT_W'(wcu_pkg::QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign pop_item  = slot_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

[hdl/wcu_back.sv]
// Back of the utilization block: per-core sample windows, window sum deltas,
// the bit-serial divider for the busy share and the output register. Uses wcu_pkg.
module wcu_back #(
	parameter int CORE_SLOTS = 5,
	parameter int WINDOW     = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  wcu_pkg::queue_item_t q_item,
	output logic                 q_pop,
	wcu_result_if.source         results
);

	localparam int CW = (CORE_SLOTS > 1) ? $clog2(CORE_SLOTS) : 1;
	localparam int PW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

	localparam int TW = wcu_pkg::TICK_W;
	localparam int UW = wcu_pkg::USAGE_W;
	localparam int AW = wcu_pkg::ACC_W;
	localparam int LOW_BITS = wcu_pkg::DIV_STEPS - wcu_pkg::SCALE_SHIFT;

	wcu_pkg::back_state_t state_q, state_d;
	logic                 load_out;

	// Window storage, one row per core
	logic [TW-1:0] idle_mem  [CORE_SLOTS][WINDOW];
	logic [TW-1:0] total_mem [CORE_SLOTS][WINDOW];

	// Per-core window state
	logic [PW-1:0] ptr_q       [CORE_SLOTS];
	logic          full_q      [CORE_SLOTS];
	logic [TW-1:0] run_idle_q  [CORE_SLOTS];
	logic [TW-1:0] run_total_q [CORE_SLOTS];
	logic [UW-1:0] last_usage_q[CORE_SLOTS];

	// Sample in flight
	logic [CW-1:0]              core_q;
	logic [wcu_pkg::CORE_W-1:0] out_core_q;
	logic [TW-1:0]              idle_q, total_q;
	logic [TW-1:0]              old_idle_q, old_total_q;
	logic [TW-1:0]              d_idle_q, d_total_q, num_q;
	logic [AW-1:0]              acc_q;
	logic [TW-1:0]              rem_q;
	logic [wcu_pkg::DIV_STEPS-1:0] shift_q;
	logic [UW-1:0]              quo_q;
	logic [wcu_pkg::STEP_W-1:0] step_q;
	logic [UW-1:0]              usage_q;
	logic                       updated_q;

	// Output register
	logic                       res_valid_q;
	logic [wcu_pkg::CORE_W-1:0] res_core_q;
	logic                       res_updated_q;
	logic [UW-1:0]              res_usage_q;

	logic [CW-1:0] head_core;
	logic [PW-1:0] cur_ptr;
	logic          cur_full;
	logic          cur_last;
	logic [AW-1:0] acc_sum;
	logic [TW:0]   trial;
	logic          trial_ge;
	logic [UW-1:0] quo_next;

	assign head_core = CW'(q_item.core);
	assign cur_ptr   = ptr_q[core_q];
	assign cur_full  = full_q[core_q];
	assign cur_last  = cur_ptr == PW'(WINDOW - 1);

	// 25 * num, built as 9 * num in B_MUL1 and + 16 * num in B_MUL2
	assign acc_sum = acc_q + (AW'(num_q) << 4);

	// One restoring division step
	assign trial    = {rem_q, shift_q[wcu_pkg::DIV_STEPS-1]};
	assign trial_ge = trial >= {1'b0, d_total_q};
	assign quo_next = {quo_q[UW-2:0], trial_ge};

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wcu_pkg::B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, pop and output load
	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			wcu_pkg::B_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					state_d = wcu_pkg::B_UPDATE;
				end
			end
			wcu_pkg::B_UPDATE: state_d = wcu_pkg::B_CHECK;
			wcu_pkg::B_CHECK: begin
				if (d_total_q == '0 || d_idle_q > d_total_q) begin
					state_d = wcu_pkg::B_DONE;
				end else begin
					state_d = wcu_pkg::B_MUL1;
				end
			end
			wcu_pkg::B_MUL1: state_d = wcu_pkg::B_MUL2;
			wcu_pkg::B_MUL2: state_d = wcu_pkg::B_DIV;
			wcu_pkg::B_DIV: begin
				if (step_q == wcu_pkg::STEP_W'(wcu_pkg::DIV_STEPS - 1)) begin
					state_d = wcu_pkg::B_DONE;
				end
			end
			wcu_pkg::B_DONE: begin
				if (!res_valid_q || results.ready) begin
					load_out = 1'b1;
					state_d  = wcu_pkg::B_IDLE;
				end
			end
			default: state_d = wcu_pkg::B_IDLE;
		endcase
	end

	// Read the oldest entry on pop, write the new sample in the cycle after
	always_ff @(posedge clk) begin
		if (q_pop) begin
			old_idle_q  <= idle_mem[head_core][ptr_q[head_core]];
			old_total_q <= total_mem[head_core][ptr_q[head_core]];
		end
		if (state_q == wcu_pkg::B_UPDATE) begin
			idle_mem[core_q][cur_ptr]  <= idle_q;
			total_mem[core_q][cur_ptr] <= total_q;
		end
	end

	// Per-core window pointer, fill flag, fill sums and last usage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CORE_SLOTS; c++) begin
				ptr_q[c]        <= '0;
				full_q[c]       <= 1'b0;
				run_idle_q[c]   <= '0;
				run_total_q[c]  <= '0;
				last_usage_q[c] <= '0;
			end
		end else begin
			if (state_q == wcu_pkg::B_UPDATE) begin
				ptr_q[core_q] <= cur_last ? '0 : cur_ptr + 1'b1;
				if (!cur_full) begin
					if (cur_last) begin
						full_q[core_q] <= 1'b1;
					end else begin
						run_idle_q[core_q]  <= run_idle_q[core_q] + idle_q;
						run_total_q[core_q] <= run_total_q[core_q] + total_q;
					end
				end
			end
			if (load_out) begin
				last_usage_q[core_q] <= usage_q;
			end
		end
	end

	// Sample datapath: deltas, scaling and division
	always_ff @(posedge clk) begin
		unique case (state_q)
			wcu_pkg::B_IDLE: begin
				if (q_valid) begin
					core_q     <= head_core;
					out_core_q <= q_item.core;
					idle_q     <= q_item.idle;
					total_q    <= q_item.total;
				end
			end
			wcu_pkg::B_UPDATE: begin
				// Published sums change by new minus oldest once full,
				// jump from zero to the whole window when it fills
				if (cur_full) begin
					d_idle_q  <= idle_q - old_idle_q;
					d_total_q <= total_q - old_total_q;
				end else if (cur_last) begin
					d_idle_q  <= run_idle_q[core_q] + idle_q;
					d_total_q <= run_total_q[core_q] + total_q;
				end else begin
					d_idle_q  <= '0;
					d_total_q <= '0;
				end
			end
			wcu_pkg::B_CHECK: begin
				updated_q <= d_total_q != '0;
				usage_q   <= (d_total_q == '0) ? last_usage_q[core_q] : '0;
				num_q     <= d_total_q - d_idle_q;
			end
			wcu_pkg::B_MUL1: begin
				acc_q <= AW'(num_q) + (AW'(num_q) << 3);
			end
			wcu_pkg::B_MUL2: begin
				// Dividend is 25 * num * 2^10; its top bits seed the remainder
				rem_q   <= acc_sum[AW-1:LOW_BITS];
				shift_q <= {acc_sum[LOW_BITS-1:0], {wcu_pkg::SCALE_SHIFT{1'b0}}};
				quo_q   <= '0;
				step_q  <= '0;
			end
			wcu_pkg::B_DIV: begin
				rem_q   <= trial_ge ? TW'(trial - {1'b0, d_total_q}) : trial[TW-1:0];
				shift_q <= shift_q << 1;
				quo_q   <= quo_next;
				step_q  <= step_q + 1'b1;
				usage_q <= (quo_next > wcu_pkg::FULL_SCALE) ? wcu_pkg::FULL_SCALE : quo_next;
			end
			wcu_pkg::B_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// Output valid: set on load, drop when the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_out) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			res_core_q    <= out_core_q;
			res_updated_q <= updated_q;
			res_usage_q   <= usage_q;
		end
	end

	assign results.valid         = res_valid_q;
	assign results.out_core      = res_core_q;
	assign results.usage_updated = res_updated_q;
	assign results.usage_q8      = res_usage_q;

endmodule

[hdl/windowed_core_utilization.sv]
// Windowed per-core utilization: top level joining front, queue and back.
// Depends on wcu_pkg, wcu_sample_if, wcu_result_if, wcu_front, wcu_queue, wcu_back.
//
// Use:
//   samples carries one beat per counter sample: a core index and eight cumulative
//   tick counters. Samples for a core index of CORE_SLOTS or more are dropped and
//   give no result. Every other sample gives exactly one beat on results: the core,
//   whether the published window total changed, and the busy share in 1/256 percent.
//   Window sums read as zero until a core has seen WINDOW samples.
// Flow:
//   The front takes a beat, folds the counters in three adder levels and pushes it
//   into a two-entry queue, and takes no new sample until that one is pushed or
//   dropped. The back updates the window of each popped sample and checks the
//   deltas; unless the window total is unchanged or the idle delta exceeds it, it
//   scales the busy delta and runs the bit-serial divider, one quotient bit per
//   cycle over 15 bits. It pops the next sample only once the result is loaded.
// Reset and stalls:
//   Reset empties every window and clears the sums and last usage values.
//   A result waits in the output register while results.ready is low; the back
//   then holds its next sample, the queue fills and samples.ready stays low.
module windowed_core_utilization #(
	parameter int CORE_SLOTS = 5,
	parameter int WINDOW     = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	wcu_sample_if.sink   samples,
	wcu_result_if.source results
);

	logic                 push, queue_full, pop, queue_valid;
	wcu_pkg::queue_item_t push_item, pop_item;

	wcu_front #(
		.CORE_SLOTS(CORE_SLOTS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (samples),
		.push      (push),
		.push_item (push_item),
		.queue_full(queue_full)
	);

	wcu_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.full     (queue_full),
		.pop      (pop),
		.pop_item (pop_item),
		.not_empty(queue_valid)
	);

	wcu_back #(
		.CORE_SLOTS(CORE_SLOTS),
		.WINDOW    (WINDOW)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_valid(queue_valid),
		.q_item (pop_item),
		.q_pop  (pop),
		.results(results)
	);

endmodule

[hdl/wcu_checker.sv]
// Port-level checks of the windowed core utilization block, and their bind.
// Depends on wcu_pkg and the top level windowed_core_utilization.
module wcu_checker #(
	parameter int CORE_SLOTS = 5
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [wcu_pkg::CORE_W-1:0]  out_core,
	input logic [wcu_pkg::USAGE_W-1:0] usage_q8
);

	// The front works on one sample at a time
	a_one_sample: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("sample taken while the front was busy");

	// A waiting result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn before it was taken");

	// Busy share never exceeds full scale
	a_usage_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> usage_q8 <= wcu_pkg::FULL_SCALE)
		else $error("usage above full scale");

	// Dropped cores never show up in results
	a_core_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> int'(out_core) < CORE_SLOTS)
		else $error("result for a core outside the configured slots");

endmodule

bind windowed_core_utilization wcu_checker #(
	.CORE_SLOTS(CORE_SLOTS)
) u_wcu_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (samples.valid),
	.in_ready (samples.ready),
	.out_valid(results.valid),
	.out_ready(results.ready),
	.out_core (results.out_core),
	.usage_q8 (results.usage_q8)
);
